FILE: src/dtm_pkg.sv
// Package for the deadline timer manager: command and result codes,
// slot table entry type, sequencer states and shared constants.
// No dependencies.
package dtm_pkg;

    localparam int DEFAULT_SLOTS = 16;

    localparam int TIME_W  = 48;
    localparam int SLOT_W  = 4;
    localparam int SECS_W  = 16;
    localparam int WAIT_W  = 32;
    localparam int CODE_W  = 2;
    localparam int MSEC_W  = 10;
    localparam int PROD_W  = SECS_W + MSEC_W;

    localparam logic [MSEC_W-1:0] MSEC_PER_SEC = MSEC_W'(1000);

    localparam logic [CODE_W-1:0] CMD_ARM    = 2'd0;
    localparam logic [CODE_W-1:0] CMD_DISARM = 2'd1;
    localparam logic [CODE_W-1:0] CMD_EXPIRE = 2'd2;

    localparam logic [CODE_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [CODE_W-1:0] KIND_EXPIRED = 2'd1;
    localparam logic [CODE_W-1:0] KIND_WAIT    = 2'd2;

    localparam logic [WAIT_W-1:0] WAIT_NONE = '1;
    localparam logic [WAIT_W-1:0] WAIT_MAX  = {1'b0, {(WAIT_W-1){1'b1}}};

    typedef struct packed {
        logic              armed;
        logic [TIME_W-1:0] deadline;
    } t_slot_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_ACK,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

endpackage

FILE: src/dtm_slot_ram.sv
// Slot table storage: one write port, one read port with registered data.
// Depends on dtm_pkg for the entry type.
module dtm_slot_ram #(
    parameter int DEPTH = dtm_pkg::DEFAULT_SLOTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  dtm_pkg::t_slot_entry i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output dtm_pkg::t_slot_entry o_rdata
);

    dtm_pkg::t_slot_entry r_mem [DEPTH];
    dtm_pkg::t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/deadline_timer_manager.sv
// Deadline timer manager top level: command sequencer, minimum scan and
// output register. Depends on dtm_pkg and dtm_slot_ram.
//
// After reset the block sweeps the slot table to clear every armed flag,
// one slot per cycle, so s_tready stays low until the sweep ends. Arm,
// disarm and unused commands go through a write state, then an acknowledge
// state that loads the acknowledgement into the output register. An expire
// check scans the slot table through a single read port and one
// subtract-compare unit; a check that expires k slots runs k + 1 scans,
// one result beat per scan. The block takes one command at a time; a
// stalled output port holds the sequencer.
module deadline_timer_manager #(
    parameter int SLOTS = dtm_pkg::DEFAULT_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // timer_slot[3:0], seconds[19:4], now_msec[67:20]
    input  logic [1:0]  i_s_tuser,   // command[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // expired_slot[3:0], wait_msec[35:4]
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
    localparam int TW = dtm_pkg::TIME_W;
    localparam int WW = dtm_pkg::WAIT_W;

    dtm_pkg::t_state r_state, n_state;

    logic [SW-1:0]                 r_idx, n_idx;
    logic [dtm_pkg::CODE_W-1:0]    r_cmd;
    logic [SW-1:0]                 r_slot;
    logic                          r_in_range;
    logic [TW-1:0]                 r_now;
    logic [dtm_pkg::PROD_W-1:0]    r_prod;

    logic                          r_rd_vld;
    logic [SW-1:0]                 r_rd_idx;
    logic                          r_best_vld;
    logic [SW-1:0]                 r_best_idx;
    logic signed [TW-1:0]          r_best_d;

    logic                          r_out_valid;
    logic [dtm_pkg::CODE_W-1:0]    r_out_kind;
    logic [dtm_pkg::SLOT_W-1:0]    r_out_slot;
    logic [WW-1:0]                 r_out_wait;
    logic                          r_out_last;

    logic                          s_accept;
    logic                          out_free;
    logic                          emit;
    logic [dtm_pkg::CODE_W-1:0]    emit_kind;
    logic [dtm_pkg::SLOT_W-1:0]    emit_slot;
    logic [WW-1:0]                 emit_wait;
    logic                          emit_last;

    logic                          wr_en;
    logic [SW-1:0]                 wr_addr;
    dtm_pkg::t_slot_entry          wr_data;
    dtm_pkg::t_slot_entry          rd_data;

    logic signed [TW-1:0]          cur_d;
    logic                          best_due;
    logic                          scan_start;

    dtm_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign cur_d      = $signed(rd_data.deadline - r_now);
    assign best_due   = r_best_d[TW-1] || (r_best_d == '0);
    assign scan_start = (r_state == dtm_pkg::S_SCAN) && (r_idx == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            dtm_pkg::S_CLEAR: begin
                if (r_idx == LAST_IDX) n_state = dtm_pkg::S_IDLE;
            end
            dtm_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser == dtm_pkg::CMD_EXPIRE) n_state = dtm_pkg::S_SCAN;
                    else                                  n_state = dtm_pkg::S_WRITE;
                end
            end
            dtm_pkg::S_WRITE: n_state = dtm_pkg::S_ACK;
            dtm_pkg::S_ACK: begin
                if (out_free) n_state = dtm_pkg::S_IDLE;
            end
            dtm_pkg::S_SCAN: begin
                if (r_idx == LAST_IDX) n_state = dtm_pkg::S_DRAIN;
            end
            dtm_pkg::S_DRAIN: n_state = dtm_pkg::S_DECIDE;
            dtm_pkg::S_DECIDE: begin
                if (out_free) begin
                    if (r_best_vld && best_due) n_state = dtm_pkg::S_SCAN;
                    else                        n_state = dtm_pkg::S_IDLE;
                end
            end
            default: n_state = dtm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready       = 1'b0;
        n_idx            = r_idx;
        wr_en            = 1'b0;
        wr_addr          = r_idx;
        wr_data.armed    = 1'b0;
        wr_data.deadline = '0;
        emit             = 1'b0;
        emit_kind        = dtm_pkg::KIND_ACK;
        emit_slot        = '0;
        emit_wait        = '0;
        emit_last        = 1'b1;
        case (r_state)
            dtm_pkg::S_CLEAR: begin
                wr_en = 1'b1;
                n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            dtm_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
            end
            dtm_pkg::S_WRITE: begin
                wr_en = r_in_range &&
                        ((r_cmd == dtm_pkg::CMD_ARM) || (r_cmd == dtm_pkg::CMD_DISARM));
                wr_addr          = r_slot;
                wr_data.armed    = (r_cmd == dtm_pkg::CMD_ARM);
                wr_data.deadline = r_now + TW'(r_prod);
            end
            dtm_pkg::S_ACK: begin
                emit = out_free;
            end
            dtm_pkg::S_SCAN: begin
                n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            dtm_pkg::S_DRAIN: begin
            end
            dtm_pkg::S_DECIDE: begin
                emit      = out_free;
                emit_kind = dtm_pkg::KIND_WAIT;
                if (!r_best_vld) begin
                    emit_wait = dtm_pkg::WAIT_NONE;
                end else if (best_due) begin
                    wr_en     = out_free;
                    wr_addr   = r_best_idx;
                    emit_kind = dtm_pkg::KIND_EXPIRED;
                    emit_slot = dtm_pkg::SLOT_W'(r_best_idx);
                    emit_last = 1'b0;
                end else if (r_best_d[TW-1:WW-1] != '0) begin
                    emit_wait = dtm_pkg::WAIT_MAX;
                end else begin
                    emit_wait = WW'(r_best_d);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtm_pkg::S_CLEAR;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_vld <= (r_state == dtm_pkg::S_SCAN);
            if (scan_start) begin
                r_best_vld <= 1'b0;
            end else if (r_rd_vld && rd_data.armed && (!r_best_vld || cur_d < r_best_d)) begin
                r_best_vld <= 1'b1;
            end
            if (emit)          r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (s_accept) begin
            r_cmd      <= i_s_tuser;
            r_slot     <= SW'(i_s_tdata[3:0]);
            r_in_range <= (32'(i_s_tdata[3:0]) < 32'(SLOTS));
            r_now      <= i_s_tdata[67:20];
            r_prod     <= dtm_pkg::PROD_W'(i_s_tdata[19:4]) *
                          dtm_pkg::PROD_W'(dtm_pkg::MSEC_PER_SEC);
        end
        if (!scan_start && r_rd_vld && rd_data.armed && (!r_best_vld || cur_d < r_best_d)) begin
            r_best_idx <= r_rd_idx;
            r_best_d   <= cur_d;
        end
        if (emit) begin
            r_out_kind <= emit_kind;
            r_out_slot <= emit_slot;
            r_out_wait <= emit_wait;
            r_out_last <= emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_wait, r_out_slot};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

FILE: dv/tb_deadline_timer_manager.sv
// Testbench for deadline_timer_manager: drives arm, disarm and expire commands over
// the input stream and checks every result beat against a slot table predictor.
// Depends on dtm_pkg and the deadline_timer_manager RTL.

typedef struct {
    logic [1:0]  kind;
    logic [3:0]  slot_id;
    logic [31:0] wait_ms;
    logic        is_last;
} t_timer_beat;

class timer_table_model;
    logic [dtm_pkg::TIME_W-1:0] deadline_ms [dtm_pkg::DEFAULT_SLOTS];
    bit                         armed [dtm_pkg::DEFAULT_SLOTS];
    t_timer_beat                pending_reports [$];
    int                         mismatches;

    function void push_report(logic [1:0] kind, logic [3:0] slot_id, logic [31:0] wait_ms,
                              logic is_last);
        t_timer_beat beat;
        beat.kind    = kind;
        beat.slot_id = slot_id;
        beat.wait_ms = wait_ms;
        beat.is_last = is_last;
        pending_reports.push_back(beat);
    endfunction

    function void apply_command(logic [1:0] cmd, logic [3:0] slot_id, logic [15:0] secs,
                                logic [47:0] now_ms);
        int                 best;
        logic signed [47:0] gap;
        logic signed [47:0] best_gap;
        if (cmd == dtm_pkg::CMD_ARM) begin
            deadline_ms[slot_id] = now_ms + {32'd0, secs} * 48'(dtm_pkg::MSEC_PER_SEC);
            armed[slot_id] = 1'b1;
        end else if (cmd == dtm_pkg::CMD_DISARM) begin
            armed[slot_id] = 1'b0;
        end
        if (cmd != dtm_pkg::CMD_EXPIRE) begin
            push_report(dtm_pkg::KIND_ACK, '0, '0, 1'b1);
            return;
        end
        forever begin
            best = -1;
            best_gap = '0;
            for (int i = 0; i < dtm_pkg::DEFAULT_SLOTS; i++) begin
                if (armed[i]) begin
                    gap = deadline_ms[i] - now_ms;
                    if (best < 0 || gap < best_gap) begin
                        best = i;
                        best_gap = gap;
                    end
                end
            end
            if (best < 0) begin
                push_report(dtm_pkg::KIND_WAIT, '0, dtm_pkg::WAIT_NONE, 1'b1);
                return;
            end
            if (best_gap > 0) begin
                push_report(dtm_pkg::KIND_WAIT, '0,
                            (best_gap > $signed({16'd0, dtm_pkg::WAIT_MAX})) ?
                            dtm_pkg::WAIT_MAX : best_gap[31:0], 1'b1);
                return;
            end
            armed[best] = 1'b0;
            push_report(dtm_pkg::KIND_EXPIRED, 4'(best), '0, 1'b0);
        end
    endfunction

    function void check_beat(logic [1:0] kind, logic [3:0] slot_id, logic [31:0] wait_ms,
                             logic is_last);
        t_timer_beat want;
        if (pending_reports.size() == 0) begin
            $error("result beat with nothing pending: kind %0d slot %0d wait %0d last %0d",
                   kind, slot_id, $signed(wait_ms), is_last);
            mismatches++;
            return;
        end
        want = pending_reports.pop_front();
        if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            mismatches++;
        end
        if (slot_id !== want.slot_id) begin
            $error("expired_slot: expected %0d, got %0d", want.slot_id, slot_id);
            mismatches++;
        end
        if (wait_ms !== want.wait_ms) begin
            $error("wait_msec: expected %0d, got %0d", $signed(want.wait_ms), $signed(wait_ms));
            mismatches++;
        end
        if (is_last !== want.is_last) begin
            $error("last: expected %0d, got %0d", want.is_last, is_last);
            mismatches++;
        end
    endfunction
endclass

module tb_deadline_timer_manager;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dtm_pkg::CODE_W-1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 400;
    localparam int ITEMS_PER_PHASE = 70;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata  = '0;  // timer_slot[3:0], seconds[19:4], now_msec[67:20]
    logic [1:0]  i_s_tuser  = '0;  // command[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;        // expired_slot[3:0], wait_msec[35:4]
    logic [1:0]  o_m_tuser;        // kind[1:0]
    logic        o_m_tlast;

    timer_table_model timers = new;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    logic        snk_hold = 1'b0;
    logic [47:0] clock_ms = '0;
    int          items_sent = 0;
    int          quiet_cycles = 0;

    deadline_timer_manager #(.SLOTS(dtm_pkg::DEFAULT_SLOTS)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_tready <= !snk_hold && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            timers.check_beat(o_m_tuser, o_m_tdata[3:0], o_m_tdata[35:4], o_m_tlast);
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_deadline_timer_manager NOT OK");
        $finish;
    end

    task automatic offer_command(input logic [1:0] cmd, input logic [3:0] slot_id,
                                 input logic [15:0] secs, input logic [47:0] now_ms);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, now_ms, secs, slot_id};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        timers.apply_command(cmd, slot_id, secs, now_ms);
        items_sent++;
    endtask

    task automatic run_timer_burst();
        int          arms;
        logic [3:0]  slot_id;
        logic [15:0] secs;
        arms = $urandom_range(1, 8);
        repeat (arms) begin
            slot_id = 4'($urandom);
            secs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            if ($urandom_range(0, 5) == 0)
                offer_command(dtm_pkg::CMD_DISARM, slot_id, secs, clock_ms);
            else
                offer_command(dtm_pkg::CMD_ARM, slot_id, secs, clock_ms);
            clock_ms += $urandom_range(0, 3000);
        end
        clock_ms += $urandom_range(0, 25000);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'($urandom), 16'($urandom), clock_ms);
    endtask

    // arm every slot on one deadline, then expire them all as a tie
    task automatic run_full_table();
        logic [15:0] secs;
        secs = 16'($urandom_range(0, 5));
        for (int s = 0; s < dtm_pkg::DEFAULT_SLOTS; s++)
            offer_command(dtm_pkg::CMD_ARM, 4'(s), secs, clock_ms);
        clock_ms += 5000 + $urandom_range(0, 2000);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'($urandom), 16'($urandom), clock_ms);
    endtask

    task automatic run_random_phase(input int src_pct, input int snk_pct);
        int stop_at;
        int pick;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = items_sent + ITEMS_PER_PHASE;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                clock_ms = {16'($urandom), 32'($urandom)};
            else if (pick == 1)
                clock_ms = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 20000);
            if (pick < 14)
                run_timer_burst();
            else if (pick < 16)
                run_full_table();
            else
                offer_command(2'($urandom), 4'($urandom), 16'($urandom),
                              {16'($urandom), 32'($urandom)});
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer_command(dtm_pkg::CMD_EXPIRE, 4'd0, 16'd0, 48'd0);
        offer_command(dtm_pkg::CMD_ARM, 4'd0, 16'd0, 48'd0);
        offer_command(dtm_pkg::CMD_ARM, 4'd15, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'd15, 16'hFFFF, 48'd0);
        offer_command(dtm_pkg::CMD_ARM, 4'd3, 16'd5, 48'd1000);
        offer_command(dtm_pkg::CMD_ARM, 4'd7, 16'd5, 48'd1000);
        offer_command(dtm_pkg::CMD_ARM, 4'd5, 16'd2, 48'd1000);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'd0, 16'd0, 48'd7000);
        offer_command(dtm_pkg::CMD_DISARM, 4'd15, 16'd0, 48'd7000);
        offer_command(dtm_pkg::CMD_DISARM, 4'd9, 16'd0, 48'd7000);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'd0, 16'd0, 48'd7000);
        offer_command(dtm_pkg::CMD_ARM, 4'd2, 16'd10, 48'd0);
        offer_command(dtm_pkg::CMD_ARM, 4'd2, 16'd1, 48'd0);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'd0, 16'd0, 48'd1000);
        offer_command(dtm_pkg::CMD_ARM, 4'd4, 16'd0, 48'h0000_8000_0000);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'd0, 16'd0, 48'd0);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'd0, 16'd0, 48'd1);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'd0, 16'd0, 48'h8000_8000_0000);
        offer_command(CMD_UNUSED, 4'd6, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        offer_command(dtm_pkg::CMD_ARM, 4'd6, 16'd1, 48'h8000_0000_0000);
        offer_command(dtm_pkg::CMD_EXPIRE, 4'd15, 16'hFFFF, 48'h7FFF_FFFF_FFFF);

        clock_ms = 48'h8000_0000_0000;
        run_random_phase(20, 46);
        run_random_phase(46, 20);

        // stall the result side long enough for the block to back up its input
        fork
            begin
                snk_hold <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                snk_hold <= 1'b0;
            end
        join_none
        run_random_phase(0, 0);

        i_s_tvalid <= 1'b0;
        while (timers.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (timers.mismatches == 0)
            $display("tb_deadline_timer_manager OK");
        else
            $display("tb_deadline_timer_manager NOT OK");
        $finish;
    end

endmodule
